FILE: src/roi_average_luma_percent_top_defines.svh
// ----------------------------------------------------------------------------
// roi_average_luma_percent_top_defines.svh
// Assertion macros shared by the region-of-interest luma block.
// ----------------------------------------------------------------------------
`ifndef ROI_AVERAGE_LUMA_PERCENT_TOP_DEFINES_SVH
`define ROI_AVERAGE_LUMA_PERCENT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ROI_AVG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("roi_avg: implication check failed");

// next-cycle implication, disabled during reset
`define ROI_AVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("roi_avg: next-cycle check failed");

`endif

FILE: src/roi_avg_pkg.sv
// ----------------------------------------------------------------------------
// roi_avg_pkg
// Shared constants and types of the region-of-interest average luma block.
// ----------------------------------------------------------------------------
package roi_avg_pkg;

  // frame geometry
  localparam int MAX_DIM   = 4096;
  localparam int CNT_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = CNT_W + 1;
  localparam int CFG_DIM_W = 13;
  localparam int OFS_W     = 8;
  localparam int PCT_W     = 7;
  localparam int PCT_FULL  = 100;

  // window arithmetic
  localparam int PROD_W    = DIM_W + PCT_W;
  localparam int QUO_W     = DIM_W + 1;
  localparam int END_W     = QUO_W + 1;
  localparam int AREA_W    = 2 * DIM_W - 1;

  // floor(p / 100) as (p * DIV100_MUL) >> DIV100_SH, exact for p < 2**PROD_W
  localparam int     DIV100_SH    = PROD_W + 7;
  localparam longint DIV100_MUL   = ((longint'(1) <<< DIV100_SH) + 99) / 100;
  localparam int     DIV100_MUL_W = DIV100_SH - 5;

  // floor(n / 255) as (n * DIV255_MUL) >> DIV255_SH, exact for n <= 25600
  localparam int     DIV255_SH    = 23;
  localparam longint DIV255_MUL   = ((longint'(1) <<< DIV255_SH) + 254) / 255;
  localparam int     DIV255_MUL_W = 16;
  localparam int     SCALE_N_W    = 15;

  // stream payload
  localparam int LUMA_W    = 8;
  localparam int OUT_PCT_W = 7;
  localparam int TDATA_W   = 8;

  // accumulator and divider
  localparam int SUM_W  = 33;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  // cycles for the window pipeline to settle after a register write
  localparam int SETTLE_CYC = 3;
  localparam int SETTLE_W   = 2;

  // register port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH     = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CROP_LEFT_PCT   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_CROP_TOP_PCT    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_CROP_WIDTH_PCT  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_CROP_HEIGHT_PCT = REG_IDX_W'(5);

  typedef struct packed {
    logic        [CFG_DIM_W-1:0] frame_width;
    logic        [CFG_DIM_W-1:0] frame_height;
    logic signed [OFS_W-1:0]     crop_left_pct;
    logic signed [OFS_W-1:0]     crop_top_pct;
    logic        [PCT_W-1:0]     crop_width_pct;
    logic        [PCT_W-1:0]     crop_height_pct;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic scale;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } status_t;

  typedef enum logic [3:0] {
    ST_RUN    = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_SCALE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (32'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(v);
    return r;
  endfunction

endpackage

FILE: src/roi_avg_regs.sv
// ----------------------------------------------------------------------------
// roi_avg_regs
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module roi_avg_regs
  import roi_avg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              cfg_wr
);

  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= CFG_DIM_W'(1920);
      cfg.frame_height    <= CFG_DIM_W'(1080);
      cfg.crop_left_pct   <= '0;
      cfg.crop_top_pct    <= '0;
      cfg.crop_width_pct  <= '0;
      cfg.crop_height_pct <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:     cfg.frame_width     <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= pwdata[CFG_DIM_W-1:0];
        REG_CROP_LEFT_PCT:   cfg.crop_left_pct   <= pwdata[OFS_W-1:0];
        REG_CROP_TOP_PCT:    cfg.crop_top_pct    <= pwdata[OFS_W-1:0];
        REG_CROP_WIDTH_PCT:  cfg.crop_width_pct  <= pwdata[PCT_W-1:0];
        REG_CROP_HEIGHT_PCT: cfg.crop_height_pct <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:     prdata = DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT:    prdata = DATA_W'(cfg.frame_height);
      REG_CROP_LEFT_PCT:   prdata = DATA_W'(signed'(cfg.crop_left_pct));
      REG_CROP_TOP_PCT:    prdata = DATA_W'(signed'(cfg.crop_top_pct));
      REG_CROP_WIDTH_PCT:  prdata = DATA_W'(cfg.crop_width_pct);
      REG_CROP_HEIGHT_PCT: prdata = DATA_W'(cfg.crop_height_pct);
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: src/roi_avg_ctrl.sv
// ----------------------------------------------------------------------------
// roi_avg_ctrl
// Sequencer: sample intake, end-of-frame divide, scaling and result handoff.
// ----------------------------------------------------------------------------
module roi_avg_ctrl
  import roi_avg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  input  logic    cfg_wr,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t              state;
  state_t              state_next;
  logic [SETTLE_W-1:0] settle;

  // hold the input while the window pipeline catches up with a write
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_W'(SETTLE_CYC);
    end else if (cfg_wr) begin
      settle <= SETTLE_W'(SETTLE_CYC);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  assign in_ready = (state == ST_RUN) && (settle == '0) && !cfg_wr;

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.scale    = 1'b0;
    cmd.load     = 1'b0;
    unique case (state)
      ST_RUN: begin
        cmd.accept = in_ready && in_valid;
        if (cmd.accept && in_last) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = !status.div_done;
        if (status.div_done) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        cmd.load = !status.out_busy;
        if (cmd.load) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/roi_avg_dp.sv
// ----------------------------------------------------------------------------
// roi_avg_dp
// Datapath: window pipeline, position counters, accumulator, restoring
// divider, percent scaling and output register.
// ----------------------------------------------------------------------------
module roi_avg_dp
  import roi_avg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [LUMA_W-1:0]  in_luma,
  input  logic               in_last,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [OUT_PCT_W-1:0] out_pct,
  output logic               out_ok
);

  localparam int DIV100_P_W = PROD_W + DIV100_MUL_W;
  localparam int DIV255_P_W = SCALE_N_W + DIV255_MUL_W;

  function automatic logic [QUO_W-1:0] div100(input logic [PROD_W-1:0] p);
    logic [DIV100_P_W-1:0] t;
    t = DIV100_P_W'(p) * DIV100_P_W'(DIV100_MUL);
    return QUO_W'(t >> DIV100_SH);
  endfunction

  // ---- window pipeline ----
  logic               crop_en;
  logic [PCT_W-1:0]   pct_x0, pct_y0, pct_w, pct_h;
  logic [DIM_W-1:0]   fw_c, fh_c;
  logic [PROD_W-1:0]  prod_x0, prod_y0, prod_w, prod_h;
  logic [DIM_W-1:0]   fw_s1, fh_s1, fw_s2, fh_s2;
  logic [QUO_W-1:0]   x0, y0, w, h;
  logic [END_W-1:0]   x_end, y_end;
  logic [AREA_W-1:0]  area;
  logic               geom_ok;

  always_comb begin
    crop_en = (cfg.crop_width_pct != '0) && (cfg.crop_height_pct != '0) &&
              !cfg.crop_left_pct[OFS_W-1] && !cfg.crop_top_pct[OFS_W-1];
    // whole frame: origin 0 percent, size 100 percent
    pct_x0 = crop_en ? cfg.crop_left_pct[PCT_W-1:0] : '0;
    pct_y0 = crop_en ? cfg.crop_top_pct[PCT_W-1:0]  : '0;
    pct_w  = crop_en ? cfg.crop_width_pct  : PCT_W'(PCT_FULL);
    pct_h  = crop_en ? cfg.crop_height_pct : PCT_W'(PCT_FULL);
    fw_c   = clamp_dim(cfg.frame_width);
    fh_c   = clamp_dim(cfg.frame_height);
  end

  always_ff @(posedge clk) begin
    prod_x0 <= PROD_W'(fw_c) * PROD_W'(pct_x0);
    prod_y0 <= PROD_W'(fh_c) * PROD_W'(pct_y0);
    prod_w  <= PROD_W'(fw_c) * PROD_W'(pct_w);
    prod_h  <= PROD_W'(fh_c) * PROD_W'(pct_h);
    fw_s1   <= fw_c;
    fh_s1   <= fh_c;

    x0    <= div100(prod_x0);
    y0    <= div100(prod_y0);
    w     <= div100(prod_w);
    h     <= div100(prod_h);
    fw_s2 <= fw_s1;
    fh_s2 <= fh_s1;

    x_end   <= END_W'(x0) + END_W'(w);
    y_end   <= END_W'(y0) + END_W'(h);
    area    <= AREA_W'(w) * AREA_W'(h);
    geom_ok <= (w != '0) && (h != '0) &&
               (END_W'(x0) + END_W'(w) <= END_W'(fw_s2)) &&
               (END_W'(y0) + END_W'(h) <= END_W'(fh_s2));
  end

  // ---- position counters and accumulator ----
  logic [CNT_W-1:0] col, row;
  logic [SUM_W-1:0] luma_sum;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_next;
  logic             in_window;
  logic             col_wrap;

  always_comb begin
    in_window = (END_W'(col) >= END_W'(x0)) && (END_W'(col) < x_end) &&
                (END_W'(row) >= END_W'(y0)) && (END_W'(row) < y_end);
    sum_add = {1'b0, luma_sum} + (SUM_W+1)'(in_luma);
    if (!in_window) sum_next = luma_sum;
    else if (sum_add[SUM_W]) sum_next = '1;
    else sum_next = sum_add[SUM_W-1:0];
    col_wrap = (DIM_W'(col) + DIM_W'(1)) >= fw_s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_sum <= '0;
      col      <= '0;
      row      <= '0;
    end else if (cmd.accept) begin
      if (in_last) begin
        luma_sum <= '0;
        col      <= '0;
        row      <= '0;
      end else begin
        luma_sum <= sum_next;
        if (col_wrap) begin
          col <= '0;
          if (32'(row) < MAX_DIM - 1) row <= row + CNT_W'(1);
        end else begin
          col <= col + CNT_W'(1);
        end
      end
    end
  end

  // ---- restoring divider, one quotient bit per step ----
  logic [SUM_W-1:0]  div_q;
  logic [AREA_W-1:0] div_rem;
  logic [AREA_W-1:0] divisor;
  logic [DCNT_W-1:0] div_cnt;
  logic              ok_latch;
  logic [AREA_W:0]   rem_sh;
  logic              q_bit;
  logic [AREA_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {div_rem, div_q[SUM_W-1]};
    q_bit    = rem_sh >= {1'b0, divisor};
    rem_next = q_bit ? AREA_W'(rem_sh - {1'b0, divisor}) : rem_sh[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.accept && in_last) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_last) begin
      div_q    <= sum_next;
      div_rem  <= '0;
      divisor  <= area;
      ok_latch <= geom_ok;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[SUM_W-2:0], q_bit};
      div_rem <= rem_next;
    end
  end

  assign status.div_done = (div_cnt == DCNT_W'(SUM_W));

  // ---- percent scaling: (q + 1) * 100 / 255, clipped at 100 ----
  logic                  big;
  logic [SCALE_N_W-1:0]  scale_n;
  logic [DIV255_P_W-1:0] scale_p;
  logic [OUT_PCT_W-1:0]  pct_calc;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      big     <= |div_q[SUM_W-1:LUMA_W];
      scale_n <= SCALE_N_W'({1'b0, div_q[LUMA_W-1:0]} + (LUMA_W+1)'(1)) *
                 SCALE_N_W'(PCT_FULL);
    end
  end

  always_comb begin
    scale_p  = DIV255_P_W'(scale_n) * DIV255_P_W'(DIV255_MUL);
    pct_calc = big ? OUT_PCT_W'(PCT_FULL) : OUT_PCT_W'(scale_p >> DIV255_SH);
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_pct <= ok_latch ? pct_calc : '0;
      out_ok  <= ok_latch;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

FILE: src/roi_average_luma_percent_top.sv
// ----------------------------------------------------------------------------
// roi_average_luma_percent_top
// Region-of-interest average luma of a raster frame, reported in percent.
// ----------------------------------------------------------------------------
// Throughput: one luma word per cycle in a frame while no write holds it.
// After the frame_end word is accepted, the divider steps once per quotient
//   bit until done, the scale state follows and the result word is loaded;
//   the input stalls over that time, and longer while the previous result
//   word still waits on m_tready.
// A register write holds the input from its access cycle until the window
//   has settled.
// Reset: synchronous; registers return to 1920x1080 whole frame, counters and
//   sum clear, the input opens once the settle counter has run down.
module roi_average_luma_percent_top
  import roi_avg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [7:0] luma
  input  logic               s_tlast,
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [6:0] brightness_pct, [7] zero
  output logic               m_tuser,   // [0] region_ok
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

`include "roi_average_luma_percent_top_defines.svh"

  cfg_t                 cfg;
  logic                 cfg_wr;
  cmd_t                 cmd;
  status_t              status;
  logic [OUT_PCT_W-1:0] out_pct;

  roi_avg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  roi_avg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .cfg_wr   (cfg_wr),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  roi_avg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_luma   (s_tdata[LUMA_W-1:0]),
    .in_last   (s_tlast),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_pct   (out_pct),
    .out_ok    (m_tuser)
  );

  assign m_tdata = TDATA_W'(out_pct);

  `ROI_AVG_ASSERT_IMPLY(a_invalid_reads_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `ROI_AVG_ASSERT_IMPLY(a_pct_in_range, clk, rst, m_tvalid, m_tdata <= TDATA_W'(PCT_FULL))
  `ROI_AVG_ASSERT_NEXT(a_stall_after_last, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready)
  `ROI_AVG_ASSERT_NEXT(a_stall_after_write, clk, rst, psel && penable && pwrite, !s_tready)

endmodule
